### rtl/core/fct_pkg.sv
// Shared types and constants for the frustum cull tester.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_COEFS  = 4;
    localparam int PLANE_AW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    localparam int KIND_W     = 3;
    localparam int PIDX_W     = 3;
    localparam int CIDX_W     = 2;
    localparam int COEF_W     = 32;
    localparam int POS_W      = 32;
    localparam int EXT_W      = 31;

    // corner coordinate, product and accumulator widths
    localparam int CORNER_W   = POS_W + 1;
    localparam int PROD_W     = COEF_W + CORNER_W;
    localparam int BIAS_W     = COEF_W + 1 + 16;
    localparam int SUM_W      = PROD_W + 3;

    // slave tdata layout, lowest bit first
    localparam int PIDX_LSB   = 0;
    localparam int CIDX_LSB   = PIDX_LSB + PIDX_W;
    localparam int COEF_LSB   = CIDX_LSB + CIDX_W;
    localparam int PX_LSB     = COEF_LSB + COEF_W;
    localparam int PY_LSB     = PX_LSB + POS_W;
    localparam int PZ_LSB     = PY_LSB + POS_W;
    localparam int EX_LSB     = PZ_LSB + POS_W;
    localparam int EY_LSB     = EX_LSB + EXT_W;
    localparam int EZ_LSB     = EY_LSB + EXT_W;
    localparam int IN_BITS    = EZ_LSB + EXT_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 3'd0,
        KIND_POINT  = 3'd1,
        KIND_SPHERE = 3'd2,
        KIND_CUBE   = 3'd3,
        KIND_BOX    = 3'd4
    } fct_kind_t;

    localparam logic [CIDX_W-1:0] COEF_NX = 2'd0;
    localparam logic [CIDX_W-1:0] COEF_NY = 2'd1;
    localparam logic [CIDX_W-1:0] COEF_NZ = 2'd2;
    localparam logic [CIDX_W-1:0] COEF_D  = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] nz;
        logic signed [COEF_W-1:0] ny;
        logic signed [COEF_W-1:0] nx;
    } fct_plane_t;

    // object under test, held for the whole test
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [EXT_W-1:0]        ext_x;
        logic [EXT_W-1:0]        ext_y;
        logic [EXT_W-1:0]        ext_z;
    } fct_obj_t;

    // per-plane step tag traveling with the pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } fct_ctl_t;

endpackage

### rtl/core/fct_plane_mem.sv
// Plane coefficient store: NUM_PLANES rows of four 32-bit lanes, lane writes,
// registered row reads. Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_plane_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [fct_pkg::PLANE_AW-1:0]  wr_plane,
    input  logic [fct_pkg::CIDX_W-1:0]    wr_coef,
    input  logic [fct_pkg::COEF_W-1:0]    wr_data,
    input  fct_pkg::fct_ctl_t             rd_ctl,
    input  logic [fct_pkg::PLANE_AW-1:0]  rd_plane,
    output fct_pkg::fct_ctl_t             row_ctl,
    output fct_pkg::fct_plane_t           row
);
    import fct_pkg::*;

    logic [COEF_W-1:0]    mem [NUM_PLANES][NUM_COEFS];
    logic [NUM_COEFS-1:0] lane_vld_reg [NUM_PLANES];
    logic [COEF_W-1:0]    rd_data_reg [NUM_COEFS];
    logic [NUM_COEFS-1:0] rd_vld_reg;
    fct_ctl_t             row_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_plane][wr_coef] <= wr_data;
        end
        rd_data_reg <= mem[rd_plane];
    end

    // lanes never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                lane_vld_reg[i] <= '0;
            end
            rd_vld_reg  <= '0;
            row_ctl_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                lane_vld_reg[wr_plane][wr_coef] <= 1'b1;
            end
            rd_vld_reg  <= lane_vld_reg[rd_plane];
            row_ctl_reg <= rd_ctl;
        end
    end

    always_comb
    begin
        row.nx = rd_vld_reg[COEF_NX] ? rd_data_reg[COEF_NX] : '0;
        row.ny = rd_vld_reg[COEF_NY] ? rd_data_reg[COEF_NY] : '0;
        row.nz = rd_vld_reg[COEF_NZ] ? rd_data_reg[COEF_NZ] : '0;
        row.d  = rd_vld_reg[COEF_D]  ? rd_data_reg[COEF_D]  : '0;
    end

    assign row_ctl = row_ctl_reg;

endmodule

### rtl/core/fct_dist_unit.sv
// Plane distance pipeline: farthest-corner select and three multiplies,
// then two partial sums, then the sign test. Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_dist_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fct_pkg::fct_obj_t    obj,
    input  fct_pkg::fct_ctl_t    row_ctl,
    input  fct_pkg::fct_plane_t  row,
    output fct_pkg::fct_ctl_t    res_ctl,
    output logic                 behind
);
    import fct_pkg::*;

    logic                       use_ext;
    logic [EXT_W-1:0]           ey_sel;
    logic [EXT_W-1:0]           ez_sel;
    logic [EXT_W-1:0]           radius;
    logic signed [CORNER_W-1:0] cx;
    logic signed [CORNER_W-1:0] cy;
    logic signed [CORNER_W-1:0] cz;
    logic signed [COEF_W:0]     bias_q16;

    logic signed [PROD_W-1:0]   px_reg, py_reg, pz_reg;
    logic signed [BIAS_W-1:0]   bias_reg;
    logic signed [SUM_W-1:0]    sxy_reg, szb_reg;
    logic signed [SUM_W-1:0]    total;
    logic                       behind_reg;
    fct_ctl_t                   ctl1_reg, ctl2_reg, ctl3_reg;

    // Box and cube: the corner farthest along the normal decides, so each
    // axis takes +e where the normal component is >= 0 and -e otherwise.
    function automatic logic signed [CORNER_W-1:0] corner(
        input logic signed [POS_W-1:0] p,
        input logic [EXT_W-1:0]        e,
        input logic                    neg
    );
        logic [CORNER_W-1:0] pw;
        logic [CORNER_W-1:0] ew;
        pw = {p[POS_W-1], p};
        ew = {2'b00, e};
        return neg ? $signed(pw - ew) : $signed(pw + ew);
    endfunction

    always_comb
    begin
        use_ext  = (obj.kind == KIND_CUBE) || (obj.kind == KIND_BOX);
        ey_sel   = (obj.kind == KIND_CUBE) ? obj.ext_x : obj.ext_y;
        ez_sel   = (obj.kind == KIND_CUBE) ? obj.ext_x : obj.ext_z;
        radius   = (obj.kind == KIND_SPHERE) ? obj.ext_x : '0;
        cx       = corner(obj.pos_x, use_ext ? obj.ext_x : '0, row.nx[COEF_W-1]);
        cy       = corner(obj.pos_y, use_ext ? ey_sel : '0, row.ny[COEF_W-1]);
        cz       = corner(obj.pos_z, use_ext ? ez_sel : '0, row.nz[COEF_W-1]);
        bias_q16 = $signed({row.d[COEF_W-1], row.d} + {2'b00, radius});
        total    = sxy_reg + szb_reg;
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= row.nx * cx;
        py_reg   <= row.ny * cy;
        pz_reg   <= row.nz * cz;
        bias_reg <= $signed({bias_q16, 16'h0000});
        sxy_reg  <= SUM_W'(px_reg) + SUM_W'(py_reg);
        szb_reg  <= SUM_W'(pz_reg) + SUM_W'(bias_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg   <= '0;
            ctl2_reg   <= '0;
            ctl3_reg   <= '0;
            behind_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg   <= row_ctl;
            ctl2_reg   <= ctl1_reg;
            ctl3_reg   <= ctl2_reg;
            behind_reg <= ctl2_reg.vld & total[SUM_W-1];
        end
    end

    assign res_ctl = ctl3_reg;
    assign behind  = behind_reg;

endmodule

### rtl/core/frustum_cull_tester_unit.sv
// Top level of the frustum cull tester: stream handshake, plane sequencer,
// result register. Depends on fct_pkg, fct_plane_mem, fct_dist_unit.
//
//   channel   dir   carries                     accepted when
//   s_*       in    plane write or test item    s_tvalid & s_tready
//   m_*       out   inside flag, one per test   m_tvalid & m_tready
//
// A plane write leaves the unit ready for the next item. A test reads one
// plane per cycle from the coefficient store; its result passes through the
// store read, the three-stage distance pipeline and the done step. The next
// item is taken once the unit is back in the idle state, which it enters as
// the result is loaded. Only one test is in flight; a finished result waits
// in the output register while the next item is taken, and a second finished
// test stalls in the done state until that register frees. Reset leaves every
// coefficient at zero, so every test reports inside until planes are loaded.
`timescale 1ns / 1ps

module frustum_cull_tester_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // plane_index, coef_index, coef_value, pos_x, pos_y, pos_z,
    // extent_x, extent_y, extent_z
    input  logic [fct_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [fct_pkg::KIND_W-1:0]     s_tuser,     // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fct_pkg::M_TDATA_W-1:0]  m_tdata      // inside_res
);
    import fct_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } fct_state_t;

    fct_state_t          state_reg, state_next;
    logic [PLANE_AW-1:0] cnt_reg, cnt_next;
    logic                reject_reg, reject_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_inside_reg, out_inside_next;
    fct_obj_t            obj_reg, obj_next;

    logic                in_xfer;
    logic                last_plane;
    logic                is_test;
    logic [PIDX_W-1:0]   in_pidx;
    logic                wr_en;
    fct_ctl_t            rd_ctl, row_ctl, res_ctl;
    fct_plane_t          row;
    logic                behind;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_xfer    = s_tvalid & s_tready;
    assign in_pidx    = s_tdata[PIDX_LSB +: PIDX_W];
    assign last_plane = (cnt_reg == PLANE_AW'(NUM_PLANES - 1));
    assign is_test    = (s_tuser == KIND_POINT) || (s_tuser == KIND_SPHERE)
                     || (s_tuser == KIND_CUBE) || (s_tuser == KIND_BOX);
    assign wr_en      = in_xfer && (s_tuser == KIND_WRITE)
                     && ({1'b0, in_pidx} < (PIDX_W + 1)'(NUM_PLANES));

    always_comb
    begin
        rd_ctl.vld  = (state_reg == ST_ISSUE);
        rd_ctl.last = (state_reg == ST_ISSUE) && last_plane;
    end

    fct_plane_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_plane (in_pidx[PLANE_AW-1:0]),
        .wr_coef  (s_tdata[CIDX_LSB +: CIDX_W]),
        .wr_data  (s_tdata[COEF_LSB +: COEF_W]),
        .rd_ctl   (rd_ctl),
        .rd_plane (cnt_reg),
        .row_ctl  (row_ctl),
        .row      (row)
    );

    fct_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .obj     (obj_reg),
        .row_ctl (row_ctl),
        .row     (row),
        .res_ctl (res_ctl),
        .behind  (behind)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        reject_next     = reject_reg | (res_ctl.vld & behind);
        out_vld_next    = out_vld_reg & ~m_tready;
        out_inside_next = out_inside_reg;
        obj_next        = obj_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && is_test)
                begin
                    obj_next.kind  = s_tuser;
                    obj_next.pos_x = s_tdata[PX_LSB +: POS_W];
                    obj_next.pos_y = s_tdata[PY_LSB +: POS_W];
                    obj_next.pos_z = s_tdata[PZ_LSB +: POS_W];
                    obj_next.ext_x = s_tdata[EX_LSB +: EXT_W];
                    obj_next.ext_y = s_tdata[EY_LSB +: EXT_W];
                    obj_next.ext_z = s_tdata[EZ_LSB +: EXT_W];
                    cnt_next       = '0;
                    reject_next    = 1'b0;
                    state_next     = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // wrap so the store address stays in range between tests
                cnt_next = last_plane ? '0 : cnt_reg + 1'b1;
                if (last_plane)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res_ctl.vld && res_ctl.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next    = 1'b1;
                    out_inside_next = ~reject_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            reject_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            reject_reg  <= reject_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obj_reg        <= obj_next;
        out_inside_reg <= out_inside_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, out_inside_reg};

    // no distance result may surface while a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !res_ctl.vld)
        else $error("distance result while idle");

    // the plane counter stays inside the store while issuing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (cnt_reg < PLANE_AW'(NUM_PLANES - 1))
                                  || last_plane)
        else $error("plane counter past last plane");

    // a waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !(out_vld_reg && m_tready)) |=> out_vld_reg)
        else $error("result dropped before transfer");

    // a new result appears only out of the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result without finished test");

endmodule
